### src/mcr_pkg.sv
`timescale 1ns / 1ps

package mcr_pkg;

    // Internal coordinate width: centre plus a world step never overflows this.
    localparam int CW      = 36;
    // Width of the midpoint decision term and its increments.
    localparam int ERR_W   = 40;
    // Dividend width of the serial divider.
    localparam int DIV_W   = 34;
    localparam int SCALE_W = 16;
    localparam int CNT_W   = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_SPAN   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_WIN_X_MIN = 3'd0,
        REG_WIN_X_MAX = 3'd1,
        REG_WIN_Y_MIN = 3'd2,
        REG_WIN_Y_MAX = 3'd3,
        REG_SCALE     = 3'd4,
        REG_ORIGIN_X  = 3'd5,
        REG_ORIGIN_Y  = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_REJECT = 2'd1,
        CMD_STEP   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic signed [31:0]  win_x_min;
        logic signed [31:0]  win_x_max;
        logic signed [31:0]  win_y_min;
        logic signed [31:0]  win_y_max;
        logic [SCALE_W-1:0]  scale;
        logic [15:0]         origin_x;
        logic [15:0]         origin_y;
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        r;
        logic               fill;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] end_x;
        logic               last;
        logic               done;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        hi = CW'(33'sh0_7fff_ffff);
        lo = -hi - CW'(1);
        if (v > hi) begin
            return 32'sh7fff_ffff;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

### src/mcr_front.sv
`timescale 1ns / 1ps

module mcr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  mcr_pkg::cfg_t       cfg,
    input  logic                push,
    output logic                full,
    input  logic                opcode,
    input  logic signed [31:0]  center_x,
    input  logic signed [31:0]  center_y,
    input  logic [30:0]         radius,
    input  logic                fill,
    input  logic                q_pop,
    output logic                q_empty,
    output mcr_pkg::item_t      q_item
);
    import mcr_pkg::*;

    item_t              mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic signed [33:0] cx_w;
    logic signed [33:0] cy_w;
    logic signed [33:0] r_w;
    logic               reject;
    item_t              in_item;
    logic               do_push;
    logic               do_pop;

    // Bounding box test against the window, done at full signed width.
    assign cx_w = {{2{center_x[31]}}, center_x};
    assign cy_w = {{2{center_y[31]}}, center_y};
    assign r_w  = {3'b000, radius};

    assign reject = (cx_w - r_w > 34'(cfg.win_x_max)) ||
                    (cx_w + r_w < 34'(cfg.win_x_min)) ||
                    (cy_w - r_w > 34'(cfg.win_y_max)) ||
                    (cy_w + r_w < 34'(cfg.win_y_min));

    always_comb
    begin
        in_item.cmd  = opcode ? CMD_STEP : (reject ? CMD_REJECT : CMD_START);
        in_item.cx   = center_x;
        in_item.cy   = center_y;
        in_item.r    = radius;
        in_item.fill = fill;
    end

    assign full    = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### src/mcr_div.sv
`timescale 1ns / 1ps

module mcr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mcr_pkg::DIV_W-1:0]        dividend,
    input  logic [mcr_pkg::SCALE_W-1:0]      divisor,
    output logic                             done,
    output logic [mcr_pkg::DIV_W-1:0]        quotient
);
    import mcr_pkg::*;

    logic [SCALE_W-1:0] rem_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [SCALE_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               run_reg;
    logic               done_reg;
    logic [SCALE_W:0]   trial;
    logic               fits;

    // Restoring division, one quotient bit per cycle; the dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(DIV_W);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            rem_reg <= fits ? SCALE_W'(trial - {1'b0, dvs_reg}) : trial[SCALE_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

endmodule

### src/mcr_oq.sv
`timescale 1ns / 1ps

module mcr_oq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr,
    input  mcr_pkg::result_t   wr_data,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output mcr_pkg::result_t   rd_data
);
    import mcr_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### src/mcr_back.sv
`timescale 1ns / 1ps

module mcr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mcr_pkg::cfg_t     cfg,
    input  logic              q_empty,
    input  mcr_pkg::item_t    q_item,
    output logic              q_pop,
    input  logic              oq_full,
    output logic              oq_push,
    output mcr_pkg::result_t  oq_data
);
    import mcr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_INIT,
        S_PLAN,
        S_DIVX,
        S_DIVY,
        S_PUSH_PIX,
        S_PUSH_SPAN,
        S_PUSH_STAT
    } state_t;

    state_t                 state_reg;
    state_t                 ret_reg;
    logic                   busy_reg;
    logic [1:0]             sec_reg;
    logic signed [CW-1:0]   dx_reg;
    logic signed [CW-1:0]   dy_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] incu_reg;
    logic signed [ERR_W-1:0] incv_reg;
    logic [31:0]            rpx_reg;
    logic signed [31:0]     cenx_reg;
    logic signed [31:0]     ceny_reg;
    logic                   fill_reg;
    logic signed [CW-1:0]   xa_reg;
    logic signed [CW-1:0]   xb_reg;
    logic signed [CW-1:0]   py_reg;
    logic                   a_ok_reg;
    logic                   b_ok_reg;
    logic                   cur_b_reg;
    logic                   any_reg;
    logic                   pdone_reg;
    logic [DIV_W-1:0]       qx_reg;
    logic [DIV_W-1:0]       qy_reg;

    logic [SCALE_W-1:0]     s_eff;
    logic signed [CW-1:0]   s_w;
    logic signed [CW-1:0]   half_w;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;

    logic                   mirror;
    logic                   lt;
    logic                   err_neg;
    logic                   draw;
    logic                   skip;
    logic signed [CW-1:0]   tdx;
    logic signed [CW-1:0]   tdy;
    logic signed [CW-1:0]   cx_w;
    logic signed [CW-1:0]   cy_w;
    logic signed [CW-1:0]   xa;
    logic signed [CW-1:0]   xb;
    logic signed [CW-1:0]   yy;
    logic                   y_in;
    logic                   a_in;
    logic                   b_in;
    logic                   step_done;
    logic signed [CW-1:0]   cur_x;
    logic signed [CW-1:0]   x_num;
    logic signed [CW-1:0]   y_num;
    logic [47:0]            prod;

    assign s_eff  = (cfg.scale == '0) ? SCALE_W'(1) : cfg.scale;
    assign s_w    = $signed({{(CW-SCALE_W){1'b0}}, s_eff});
    assign half_w = s_w >>> 1;

    mcr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (s_eff),
        .done     (div_done),
        .quotient (div_quo)
    );

    // One midpoint step: decide whether this step draws, and mirror the
    // offsets into the current sector.
    assign mirror  = (sec_reg == 2'd0) || (sec_reg == 2'd3);
    assign lt      = dx_reg < dy_reg;
    assign err_neg = err_reg[ERR_W-1];
    assign draw    = lt ? (!(fill_reg && mirror) || !err_neg) : ((dx_reg == dy_reg) && mirror);
    assign cx_w    = CW'(cenx_reg);
    assign cy_w    = CW'(ceny_reg);

    always_comb
    begin
        skip = 1'b0;
        case (sec_reg)
            2'd1:
            begin
                tdx = dy_reg;
                tdy = dx_reg;
            end
            2'd2:
            begin
                tdx  = dy_reg;
                tdy  = -dx_reg;
                skip = (dx_reg == '0);
            end
            2'd3:
            begin
                tdx = dx_reg;
                tdy = -dy_reg;
            end
            default:
            begin
                tdx = dx_reg;
                tdy = dy_reg;
            end
        endcase
    end

    assign xa   = cx_w - tdx;
    assign xb   = cx_w + tdx;
    assign yy   = cy_w - tdy;
    assign y_in = (yy >= CW'(cfg.win_y_min)) && (yy <= CW'(cfg.win_y_max));
    assign a_in = y_in && (xa >= CW'(cfg.win_x_min)) && (xa <= CW'(cfg.win_x_max));
    assign b_in = y_in && (tdx != '0) &&
                  (xb >= CW'(cfg.win_x_min)) && (xb <= CW'(cfg.win_x_max));
    assign step_done = !lt && (sec_reg == 2'd3);

    // Pixel mapping numerators; both are non-negative for in-window points.
    assign cur_x = a_ok_reg ? xa_reg : xb_reg;
    assign x_num = cur_x - CW'(cfg.win_x_min) + half_w;
    assign y_num = py_reg - CW'(cfg.win_y_min) + half_w;

    assign prod = rpx_reg * s_eff;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = x_num[DIV_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                div_dividend = {{(DIV_W-31){1'b0}}, q_item.r};
                div_start    = !q_empty && (q_item.cmd == CMD_START);
            end
            S_PLAN:
            begin
                div_start = a_ok_reg || b_ok_reg;
            end
            S_DIVX:
            begin
                div_dividend = y_num[DIV_W-1:0];
                div_start    = div_done;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        oq_data.kind  = KIND_STATUS;
        oq_data.pos_x = '0;
        oq_data.pos_y = '0;
        oq_data.end_x = '0;
        oq_data.last  = 1'b1;
        oq_data.done  = pdone_reg;
        oq_push       = 1'b0;
        case (state_reg)
            S_PUSH_PIX:
            begin
                oq_push       = 1'b1;
                oq_data.kind  = KIND_PIXEL;
                oq_data.pos_x = sat32(CW'({1'b0, qx_reg}) + CW'(cfg.origin_x));
                oq_data.pos_y = sat32(CW'({1'b0, qy_reg}) + CW'(cfg.origin_y));
                oq_data.last  = cur_b_reg || !b_ok_reg;
            end
            S_PUSH_SPAN:
            begin
                oq_push       = 1'b1;
                oq_data.kind  = KIND_SPAN;
                oq_data.pos_x = sat32(xa_reg);
                oq_data.pos_y = sat32(py_reg);
                oq_data.end_x = sat32(xb_reg);
            end
            S_PUSH_STAT:
            begin
                oq_push = 1'b1;
            end
            default:
            begin
                oq_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            busy_reg  <= 1'b0;
            sec_reg   <= 2'd0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            err_reg   <= '0;
            incu_reg  <= '0;
            incv_reg  <= '0;
            rpx_reg   <= '0;
            cenx_reg  <= '0;
            ceny_reg  <= '0;
            fill_reg  <= 1'b0;
            a_ok_reg  <= 1'b0;
            b_ok_reg  <= 1'b0;
            cur_b_reg <= 1'b0;
            any_reg   <= 1'b0;
            pdone_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty) begin
                        case (q_item.cmd)
                            CMD_START:
                            begin
                                busy_reg  <= 1'b0;
                                cenx_reg  <= q_item.cx;
                                ceny_reg  <= q_item.cy;
                                fill_reg  <= q_item.fill;
                                state_reg <= S_RDIV;
                            end
                            CMD_STEP:
                            begin
                                if (!busy_reg) begin
                                    pdone_reg <= 1'b1;
                                    state_reg <= S_PUSH_STAT;
                                end else begin
                                    xa_reg    <= xa;
                                    xb_reg    <= xb;
                                    py_reg    <= yy;
                                    a_ok_reg  <= draw && !skip && !fill_reg && a_in;
                                    b_ok_reg  <= draw && !skip && !fill_reg && b_in;
                                    any_reg   <= 1'b0;
                                    pdone_reg <= step_done;
                                    if (lt) begin
                                        incu_reg <= incu_reg + ERR_W'(2);
                                        if (err_neg) begin
                                            incv_reg <= incv_reg + ERR_W'(2);
                                            err_reg  <= err_reg + incu_reg + ERR_W'(2);
                                        end else begin
                                            incv_reg <= incv_reg + ERR_W'(4);
                                            err_reg  <= err_reg + incv_reg + ERR_W'(4);
                                            dy_reg   <= dy_reg - s_w;
                                        end
                                        dx_reg <= dx_reg + s_w;
                                    end else if (sec_reg == 2'd3) begin
                                        busy_reg <= 1'b0;
                                        sec_reg  <= 2'd0;
                                    end else begin
                                        sec_reg <= sec_reg + 2'd1;
                                    end
                                    if (draw && !skip && fill_reg) begin
                                        ret_reg <= S_PUSH_SPAN;
                                    end else begin
                                        ret_reg <= S_PLAN;
                                    end
                                    if (!lt && (sec_reg != 2'd3)) begin
                                        state_reg <= S_INIT;
                                    end else if (draw && !skip && fill_reg) begin
                                        state_reg <= S_PUSH_SPAN;
                                    end else begin
                                        state_reg <= S_PLAN;
                                    end
                                end
                            end
                            default:
                            begin
                                busy_reg  <= 1'b0;
                                pdone_reg <= 1'b1;
                                state_reg <= S_PUSH_STAT;
                            end
                        endcase
                    end
                end
                S_RDIV:
                begin
                    if (div_done) begin
                        if (div_quo == '0) begin
                            pdone_reg <= 1'b1;
                            state_reg <= S_PUSH_STAT;
                        end else begin
                            rpx_reg   <= div_quo[31:0];
                            sec_reg   <= 2'd0;
                            busy_reg  <= 1'b1;
                            pdone_reg <= 1'b0;
                            ret_reg   <= S_PUSH_STAT;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    dx_reg    <= '0;
                    dy_reg    <= CW'(prod);
                    err_reg   <= ERR_W'(1) - $signed({{(ERR_W-32){1'b0}}, rpx_reg});
                    incu_reg  <= ERR_W'(1);
                    incv_reg  <= ERR_W'(1) - $signed({{(ERR_W-33){1'b0}}, rpx_reg, 1'b0});
                    state_reg <= ret_reg;
                end
                S_PLAN:
                begin
                    if (a_ok_reg || b_ok_reg) begin
                        cur_b_reg <= !a_ok_reg;
                        state_reg <= S_DIVX;
                    end else if (!any_reg && pdone_reg) begin
                        state_reg <= S_PUSH_STAT;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIVX:
                begin
                    if (div_done) begin
                        qx_reg    <= div_quo;
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY:
                begin
                    if (div_done) begin
                        qy_reg    <= div_quo;
                        state_reg <= S_PUSH_PIX;
                    end
                end
                S_PUSH_PIX:
                begin
                    if (!oq_full) begin
                        any_reg <= 1'b1;
                        if (cur_b_reg) begin
                            b_ok_reg <= 1'b0;
                        end else begin
                            a_ok_reg <= 1'b0;
                        end
                        state_reg <= S_PLAN;
                    end
                end
                S_PUSH_SPAN, S_PUSH_STAT:
                begin
                    if (!oq_full) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/midpoint_circle_rasterizer.sv
`timescale 1ns / 1ps

// Midpoint circle rasterizer with a queue-style interface on both sides. A
// start item is answered by one status item once the serial division of the
// radius by scale is through; a rejected start is answered by its status item
// directly. Each visible outline pixel sends both of its screen coordinates
// through the same one-bit-per-cycle scale divider. A step that ends a sector
// passes through S_INIT for the multiply that reloads the sector. Items queue
// in a two-entry input buffer and results in a two-entry output buffer, so
// either side may stall without holding up the other.
module midpoint_circle_rasterizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               opcode,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic [30:0]        radius,
    input  logic               fill,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         kind,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] span_end_x,
    output logic               last,
    output logic               done_res,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_data
);
    import mcr_pkg::*;

    cfg_t    cfg_reg;
    logic    q_empty;
    logic    q_pop;
    item_t   q_item;
    logic    oq_full;
    logic    oq_push;
    result_t oq_wdata;
    result_t oq_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.win_x_min <= 32'sd0;
            cfg_reg.win_x_max <= 32'sd1023;
            cfg_reg.win_y_min <= 32'sd0;
            cfg_reg.win_y_max <= 32'sd767;
            cfg_reg.scale     <= SCALE_W'(1);
            cfg_reg.origin_x  <= 16'd0;
            cfg_reg.origin_y  <= 16'd0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_idx))
                REG_WIN_X_MIN: cfg_reg.win_x_min <= cfg_data;
                REG_WIN_X_MAX: cfg_reg.win_x_max <= cfg_data;
                REG_WIN_Y_MIN: cfg_reg.win_y_min <= cfg_data;
                REG_WIN_Y_MAX: cfg_reg.win_y_max <= cfg_data;
                REG_SCALE:     cfg_reg.scale     <= cfg_data[SCALE_W-1:0];
                REG_ORIGIN_X:  cfg_reg.origin_x  <= cfg_data[15:0];
                REG_ORIGIN_Y:  cfg_reg.origin_y  <= cfg_data[15:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    mcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .full     (full),
        .opcode   (opcode),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .fill     (fill),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .q_item   (q_item)
    );

    mcr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .oq_full (oq_full),
        .oq_push (oq_push),
        .oq_data (oq_wdata)
    );

    mcr_oq u_oq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (oq_push),
        .wr_data (oq_wdata),
        .full    (oq_full),
        .pop     (pop),
        .empty   (empty),
        .rd_data (oq_rdata)
    );

    assign kind       = oq_rdata.kind;
    assign pos_x      = oq_rdata.pos_x;
    assign pos_y      = oq_rdata.pos_y;
    assign span_end_x = oq_rdata.end_x;
    assign last       = oq_rdata.last;
    assign done_res   = oq_rdata.done;

endmodule

### src/mcr_checker.sv
`timescale 1ns / 1ps

module mcr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [1:0]         kind,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] span_end_x,
    input logic               last
);
    import mcr_pkg::*;

    // A waiting result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before pop");

    // A status item is always the only item of its input item.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_STATUS) |-> (last && pos_x == 0 && pos_y == 0))
        else $error("malformed status item");

    // Screen pixels are never negative and carry no span end.
    a_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_PIXEL) |-> (span_end_x == 0 && !pos_x[31] && !pos_y[31]))
        else $error("malformed pixel item");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (kind != 2'd3))
        else $error("undefined result kind");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .span_end_x (span_end_x),
    .last       (last)
);
